// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

   // Store geometry and field widths.
   localparam int Depth      = 16;
   localparam int KeyWidth   = 32;
   localparam int CountWidth = 5;
   localparam int CsrIdxWidth  = 8;
   localparam int CsrDataWidth = 32;

   // Capacity after reset.
   localparam logic [CountWidth-1:0] CapacityReset = CountWidth'(16);

   // Register indexes of the configuration port.
   localparam logic [CsrIdxWidth-1:0] CsrCapacity = CsrIdxWidth'(0);
   localparam logic [CsrIdxWidth-1:0] CsrOrder    = CsrIdxWidth'(1);

   typedef enum logic {
      ActInsert = 1'b0,
      ActRemove = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      StatusDone  = 2'd0,
      StatusFull  = 2'd1,
      StatusEmpty = 2'd2
   } status_type;

   // Ranking rule: largest key at the head or smallest key at the head.
   typedef enum logic {
      OrderLargest  = 1'b0,
      OrderSmallest = 1'b1
   } order_type;

   typedef struct packed {
      action_type           action;
      logic [KeyWidth-1:0]  key;
   } req_type;

   typedef struct packed {
      logic [KeyWidth-1:0]   head_key;
      status_type            status;
      logic [CountWidth-1:0] occupancy;
   } rsp_type;

   // Broadcast control that every cell of the row sees.
   typedef struct packed {
      logic                 ins_en;
      logic                 rem_en;
      order_type            order;
      logic [KeyWidth-1:0]  key;
   } cell_ctrl_type;

endpackage

// ----- rtl/spq_cell.sv -----
`timescale 1ns / 1ps

module spq_cell
   import spq_pkg::*;
(
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic                occupied,
   input  logic                left_stay,
   input  logic                right_stay,
   input  logic [KeyWidth-1:0] left_entry,
   input  logic [KeyWidth-1:0] right_entry,
   output logic                stay,
   output logic [KeyWidth-1:0] entry
);

   logic [KeyWidth-1:0] entry_ff;
   logic [KeyWidth-1:0] entry_in;
   logic                above;

   // The new key ranks strictly above the stored one.
   assign above = (ctrl.order == OrderSmallest) ? (ctrl.key < entry_ff)
                                                : (ctrl.key > entry_ff);

   // A cell keeps its place when its own entry, or any occupied entry behind it,
   // ranks equal or higher than the new key, so the new key lands behind the last such entry.
   assign stay  = (occupied && !above) || right_stay;
   assign entry = entry_ff;

   // On insert the first non-staying cell takes the key and the rest shift back;
   // on remove every cell but the last takes its right neighbour, and the last keeps its own.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins_en) begin
         if (stay) begin
            entry_in = entry_ff;
         end else if (left_stay) begin
            entry_in = ctrl.key;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctrl.rem_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- rtl/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// The result of a request is registered and presented in the cycle after it is accepted.
// One request per cycle unless the result stalls; the cells compare and shift on acceptance.
// A stalled result holds the output register and the request side stalls behind it.
// Reset clears the entry count, the output valid and restores the configuration defaults;
// the key store is not cleared.

module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_data
);

   logic [CountWidth-1:0] count_ff, count_in;
   logic [CountWidth-1:0] capacity_ff;
   order_type             order_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  req_accept;
   logic [CountWidth-1:0] cap_eff;
   logic                  full;
   logic                  empty;
   cell_ctrl_type         ctrl;

   logic [KeyWidth-1:0]   entry_w [Depth];
   logic                  stay_w  [Depth];

   // Handshake: a request is taken whenever the output register can take its result.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Capacity saturates at the store depth.
   assign cap_eff = (capacity_ff > CountWidth'(Depth)) ? CountWidth'(Depth) : capacity_ff;
   assign full    = count_ff >= cap_eff;
   assign empty   = count_ff == '0;

   // Broadcast control for the cell row.
   always_comb begin
      ctrl.ins_en = req_accept && (req_data.action == ActInsert) && !full;
      ctrl.rem_en = req_accept && (req_data.action == ActRemove) && !empty;
      ctrl.order  = order_ff;
      ctrl.key    = req_data.key;
   end

   // The row of cells, head at position zero.
   for (genvar i = 0; i < Depth; i++) begin : g_cell
      logic                occ;
      logic                lstay;
      logic                rstay;
      logic [KeyWidth-1:0] lentry;
      logic [KeyWidth-1:0] rentry;

      assign occ = count_ff > CountWidth'(i);

      if (i == 0) begin : g_first
         assign lstay  = 1'b1;
         assign lentry = req_data.key;
      end else begin : g_mid
         assign lstay  = stay_w[i-1];
         assign lentry = entry_w[i-1];
      end

      if (i == Depth - 1) begin : g_last
         assign rstay  = 1'b0;
         assign rentry = entry_w[i];
      end else begin : g_notlast
         assign rstay  = stay_w[i+1];
         assign rentry = entry_w[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occ),
         .left_stay   (lstay),
         .right_stay  (rstay),
         .left_entry  (lentry),
         .right_entry (rentry),
         .stay        (stay_w[i]),
         .entry       (entry_w[i])
      );
   end

   // Count update and result formation.
   always_comb begin
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctrl.ins_en) begin
         count_in = count_ff + CountWidth'(1);
      end else if (ctrl.rem_en) begin
         count_in = count_ff - CountWidth'(1);
      end
      if (req_accept) begin
         rsp_valid_in     = 1'b1;
         rsp_in.head_key  = ctrl.rem_en ? entry_w[0] : '0;
         rsp_in.occupancy = count_in;
         if (req_data.action == ActInsert) begin
            rsp_in.status = full ? StatusFull : StatusDone;
         end else begin
            rsp_in.status = empty ? StatusEmpty : StatusDone;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= CapacityReset;
         order_ff     <= OrderLargest;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CsrCapacity) begin
               capacity_ff <= csr_data[CountWidth-1:0];
            end else if (csr_index == CsrOrder) begin
               order_ff <= order_type'(csr_data[0]);
            end
         end
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // The count never exceeds the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(Depth))
      else $error("entry count above depth");

   // A remove on an empty queue reports empty with a zero key.
   a_empty_remove: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.action == ActRemove && empty) |=>
      (rsp_valid_ff && rsp_ff.status == StatusEmpty && rsp_ff.head_key == '0))
      else $error("remove on empty not flagged");

   // A successful insert grows the count by one and reports it.
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.action == ActInsert && !full) |=>
      (count_ff == $past(count_ff) + CountWidth'(1) && rsp_ff.occupancy == count_ff))
      else $error("insert count mismatch");

endmodule
